// ----- src/matrix_multiply_unit_defines.svh -----
// Assertion macros shared by the matrix multiply unit.
`ifndef MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define MATRIX_MULTIPLY_UNIT_DEFINES_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define MMU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define MMU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mmu_pkg.sv -----
// Shared types and constants of the matrix multiply unit.
package mmu_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int VALUE_W    = 32;
  localparam int OUT_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd4;

  localparam logic [1:0] OP_WRITE_A = 2'd0;
  localparam logic [1:0] OP_WRITE_B = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic rd;
    logic first;
    logic last_k;
    logic last_res;
  } dp_cmd_t;

  // Tag that travels down the datapath pipeline with each product.
  typedef struct packed {
    logic                 valid;
    logic                 first;
    logic                 last_k;
    logic                 last_res;
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_IDX_W-1:0] col;
  } tag_t;

endpackage

// ----- src/mmu_ctrl.sv -----
// Controller: configuration registers, command decode and the index sequencer.
module mmu_ctrl #(
  parameter int MAX_DIM = 8,
  parameter int IDX_W   = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [mmu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           start,
  input  logic [1:0]                     opcode,
  output logic                           busy,
  output mmu_pkg::dp_cmd_t               cmd,
  output logic [IDX_W-1:0]               idx_row,
  output logic [IDX_W-1:0]               idx_col,
  output logic [IDX_W-1:0]               idx_k
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                           state;
  logic [mmu_pkg::CFG_DATA_W-1:0] row_count;
  logic [mmu_pkg::CFG_DATA_W-1:0] inner_count;
  logic [mmu_pkg::CFG_DATA_W-1:0] col_count;
  logic [IDX_W-1:0]               rows_m1;
  logic [IDX_W-1:0]               inner_m1;
  logic [IDX_W-1:0]               cols_m1;
  logic [IDX_W-1:0]               j;
  logic [IDX_W-1:0]               i;
  logic [IDX_W-1:0]               k;
  logic                           accept;
  logic                           k_end;
  logic                           i_end;
  logic                           j_end;

  // A count of zero acts as one and a count above MAX_DIM acts as MAX_DIM.
  function automatic logic [IDX_W-1:0] dim_m1(input logic [mmu_pkg::CFG_DATA_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > MAX_DIM) begin
      r = IDX_W'(MAX_DIM - 1);
    end else begin
      r = IDX_W'(v - 1'b1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= mmu_pkg::DIM_RESET;
      inner_count <= mmu_pkg::DIM_RESET;
      col_count   <= mmu_pkg::DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mmu_pkg::REG_ROW_COUNT:   row_count   <= cfg_data;
        mmu_pkg::REG_INNER_COUNT: inner_count <= cfg_data;
        mmu_pkg::REG_COL_COUNT:   col_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy   = (state == ST_RUN);
  assign accept = start && !busy;
  assign k_end  = (k == inner_m1);
  assign i_end  = (i == cols_m1);
  assign j_end  = (j == rows_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && opcode == mmu_pkg::OP_COMPUTE) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (k_end && i_end && j_end) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Walks k fastest, then the result column, then the result row.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      rows_m1  <= dim_m1(row_count);
      inner_m1 <= dim_m1(inner_count);
      cols_m1  <= dim_m1(col_count);
      j        <= '0;
      i        <= '0;
      k        <= '0;
    end else if (k_end) begin
      k <= '0;
      if (i_end) begin
        i <= '0;
        j <= j + 1'b1;
      end else begin
        i <= i + 1'b1;
      end
    end else begin
      k <= k + 1'b1;
    end
  end

  always_comb begin
    cmd.wr_a     = accept && (opcode == mmu_pkg::OP_WRITE_A);
    cmd.wr_b     = accept && (opcode == mmu_pkg::OP_WRITE_B);
    cmd.rd       = busy;
    cmd.first    = (k == '0);
    cmd.last_k   = k_end;
    cmd.last_res = i_end && j_end;
  end

  assign idx_row = j;
  assign idx_col = i;
  assign idx_k   = k;

endmodule

// ----- src/mmu_dp.sv -----
// Datapath: element stores, multiplier, accumulator and saturating output stage.
module mmu_dp #(
  parameter int MAX_DIM = 8,
  parameter int IDX_W   = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mmu_pkg::dp_cmd_t                    cmd,
  input  logic [IDX_W-1:0]                    idx_row,
  input  logic [IDX_W-1:0]                    idx_col,
  input  logic [IDX_W-1:0]                    idx_k,
  input  logic [2:0]                          elem_row,
  input  logic [2:0]                          elem_col,
  input  logic signed [mmu_pkg::VALUE_W-1:0]  elem_value,
  output logic                                result_valid,
  output logic [mmu_pkg::OUT_IDX_W-1:0]       out_row,
  output logic [mmu_pkg::OUT_IDX_W-1:0]       out_col,
  output logic signed [mmu_pkg::VALUE_W-1:0]  out_value,
  output logic                                saturated,
  output logic                                last
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PROD_W = 2 * mmu_pkg::VALUE_W;

  logic [mmu_pkg::VALUE_W-1:0] mem_a [DEPTH];
  logic [mmu_pkg::VALUE_W-1:0] mem_b [DEPTH];

  logic                               wr_ok;
  logic [ADDR_W-1:0]                  wr_addr;
  logic [ADDR_W-1:0]                  rd_addr_a;
  logic [ADDR_W-1:0]                  rd_addr_b;
  logic signed [mmu_pkg::VALUE_W-1:0] a_q;
  logic signed [mmu_pkg::VALUE_W-1:0] b_q;
  logic signed [PROD_W-1:0]           prod_q;
  logic signed [PROD_W-1:0]           prod_shift;
  logic signed [PROD_W-1:0]           acc;
  logic                               sat_hi;
  logic                               sat_lo;
  mmu_pkg::tag_t                      tag0;
  mmu_pkg::tag_t                      tag1;
  mmu_pkg::tag_t                      tag2;
  mmu_pkg::tag_t                      tag3;

  // Writes outside the MAX_DIM x MAX_DIM grid are dropped.
  assign wr_ok   = (int'(elem_row) < MAX_DIM) && (int'(elem_col) < MAX_DIM);
  assign wr_addr = ADDR_W'(ADDR_W'(elem_row) * ADDR_W'(MAX_DIM)) + ADDR_W'(elem_col);

  assign rd_addr_a = ADDR_W'(ADDR_W'(idx_row) * ADDR_W'(MAX_DIM)) + ADDR_W'(idx_k);
  assign rd_addr_b = ADDR_W'(ADDR_W'(idx_k) * ADDR_W'(MAX_DIM)) + ADDR_W'(idx_col);

  always_ff @(posedge clk) begin
    if (cmd.wr_a && wr_ok) begin
      mem_a[wr_addr] <= elem_value;
    end
    if (cmd.rd) begin
      a_q <= mem_a[rd_addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b && wr_ok) begin
      mem_b[wr_addr] <= elem_value;
    end
    if (cmd.rd) begin
      b_q <= mem_b[rd_addr_b];
    end
  end

  always_comb begin
    tag0.valid    = cmd.rd;
    tag0.first    = cmd.first;
    tag0.last_k   = cmd.last_k;
    tag0.last_res = cmd.last_res;
    tag0.row      = mmu_pkg::OUT_IDX_W'(idx_row);
    tag0.col      = mmu_pkg::OUT_IDX_W'(idx_col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
      tag2.valid <= 1'b0;
      tag3.valid <= 1'b0;
    end else begin
      tag1.valid <= tag0.valid;
      tag2.valid <= tag1.valid;
      tag3.valid <= tag2.valid;
    end
    tag1[$bits(mmu_pkg::tag_t)-2:0] <= tag0[$bits(mmu_pkg::tag_t)-2:0];
    tag2[$bits(mmu_pkg::tag_t)-2:0] <= tag1[$bits(mmu_pkg::tag_t)-2:0];
    tag3[$bits(mmu_pkg::tag_t)-2:0] <= tag2[$bits(mmu_pkg::tag_t)-2:0];
  end

  always_ff @(posedge clk) begin
    prod_q <= a_q * b_q;
  end

  // The arithmetic shift rounds each product toward minus infinity.
  assign prod_shift = prod_q >>> 16;

  always_ff @(posedge clk) begin
    if (tag2.valid) begin
      acc <= tag2.first ? prod_shift : acc + prod_shift;
    end
  end

  assign sat_hi = (acc > 64'sd2147483647);
  assign sat_lo = (acc < -64'sd2147483648);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= tag3.valid && tag3.last_k;
    end
    out_row   <= tag3.row;
    out_col   <= tag3.col;
    last      <= tag3.last_res;
    saturated <= sat_hi || sat_lo;
    if (sat_hi) begin
      out_value <= 32'sh7FFFFFFF;
    end else if (sat_lo) begin
      out_value <= 32'sh80000000;
    end else begin
      out_value <= acc[mmu_pkg::VALUE_W-1:0];
    end
  end

endmodule

// ----- src/matrix_multiply_unit.sv -----
// Top level of the fixed-point matrix multiply unit.
//
//  Channel   Handshake                 Payload
//  config    cfg_write                 cfg_index, cfg_data
//  command   start while busy is low   opcode, elem_row, elem_col, elem_value
//  result    result_valid, one cycle   out_row, out_col, out_value, saturated, last
//
// A write item never raises busy.
// A compute item holds busy while the sequencer walks every inner term of every result:
// one entry of each store is read per cycle and fed to the single multiply-accumulate chain.
// Each result passes the store read registers, the product register, the accumulator and the output register.
// Reset clears the control state and sets all three counts to four; the stores
// are not cleared. Results cannot be stalled by the receiver.
`include "matrix_multiply_unit_defines.svh"

module matrix_multiply_unit #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mmu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mmu_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          opcode,
  input  logic [2:0]                          elem_row,
  input  logic [2:0]                          elem_col,
  input  logic signed [mmu_pkg::VALUE_W-1:0]  elem_value,
  output logic                                result_valid,
  output logic [mmu_pkg::OUT_IDX_W-1:0]       out_row,
  output logic [mmu_pkg::OUT_IDX_W-1:0]       out_col,
  output logic signed [mmu_pkg::VALUE_W-1:0]  out_value,
  output logic                                saturated,
  output logic                                last
);

  localparam int IDX_W = $clog2(MAX_DIM);

  mmu_pkg::dp_cmd_t  cmd;
  logic [IDX_W-1:0]  idx_row;
  logic [IDX_W-1:0]  idx_col;
  logic [IDX_W-1:0]  idx_k;

  mmu_ctrl #(
    .MAX_DIM (MAX_DIM),
    .IDX_W   (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .start       (start),
    .opcode      (opcode),
    .busy        (busy),
    .cmd         (cmd),
    .idx_row     (idx_row),
    .idx_col     (idx_col),
    .idx_k       (idx_k)
  );

  mmu_dp #(
    .MAX_DIM (MAX_DIM),
    .IDX_W   (IDX_W)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .idx_row      (idx_row),
    .idx_col      (idx_col),
    .idx_k        (idx_k),
    .elem_row     (elem_row),
    .elem_col     (elem_col),
    .elem_value   (elem_value),
    .result_valid (result_valid),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_value    (out_value),
    .saturated    (saturated),
    .last         (last)
  );

  // A compute transfer must start the sequencer on the next cycle.
  `MMU_ASSERT_NEXT(a_compute_starts, clk, rst, start && !busy && opcode == mmu_pkg::OP_COMPUTE, busy, "compute transfer did not raise busy")
  // Every result comes from an earlier read of the last inner term of its dot product.
  `MMU_ASSERT_SAME(a_result_source, clk, rst, result_valid, $past(cmd.rd && cmd.last_k, 4), "result without a finished dot product")
  // The flagged last result belongs to the final row and column.
  `MMU_ASSERT_SAME(a_last_source, clk, rst, result_valid && last, $past(cmd.last_res, 4), "last flag on a result that is not the final one")
  // The sequencer only stops after issuing the final inner term of the final result.
  `MMU_ASSERT_SAME(a_busy_end, clk, rst, $fell(busy), $past(cmd.rd && cmd.last_k && cmd.last_res), "sequencer stopped early")

endmodule
